### design/pcanon_pkg.sv
// Shared types and constants for the path canonicalizer.
// Used by pcanon_front, pcanon_back and path_canonicalizer; no dependencies.
package pcanon_pkg;

	localparam int PATH_CAP    = 256;
	localparam int ADDR_W      = $clog2(PATH_CAP);
	localparam int LEN_W       = ADDR_W + 1;
	localparam int POS_W       = LEN_W + 1;
	localparam int STACK_DEPTH = 32;
	localparam int SP_W        = $clog2(STACK_DEPTH);
	localparam int SD_W        = SP_W + 1;
	localparam int NAME_LIMIT  = 64;
	localparam int CC_W        = $clog2(NAME_LIMIT);
	localparam int QUEUE_DEPTH = 4;
	localparam int QP_W        = $clog2(QUEUE_DEPTH);

	localparam logic [2:0] OP_START  = 3'd0;
	localparam logic [2:0] OP_BASE   = 3'd1;
	localparam logic [2:0] OP_INPUT  = 3'd2;
	localparam logic [2:0] OP_FINISH = 3'd3;
	localparam logic [2:0] OP_READ   = 3'd4;

	localparam logic REG_OUTPUT_SIZE = 1'b0;
	localparam logic REG_SEPARATOR   = 1'b1;

	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_DRIVE = 8'h43;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LZ    = 8'h7A;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UZ    = 8'h5A;
	localparam logic [7:0] CASE_GAP = 8'd32;
	localparam logic [7:0] CH_BACKSLASH = 8'h5C;

	localparam logic [LEN_W-1:0] ROOT_LEN  = LEN_W'(3);
	localparam logic [LEN_W-1:0] MIN_SIZE  = LEN_W'(4);
	localparam logic [LEN_W-1:0] RESET_SIZE = LEN_W'(PATH_CAP);

	typedef struct packed {
		logic       is_start;
		logic       is_base;
		logic       is_input;
		logic       is_finish;
		logic       is_read;
		logic [7:0] ch;
		logic [7:0] idx;
	} cmd_t;

	typedef struct packed {
		logic [LEN_W-1:0] buf_size;
		logic [7:0]       sep;
	} cfg_t;

endpackage

### design/pcanon_front.sv
// Front end: accepts items, decodes the operation and queues them.
// Depends on pcanon_pkg.
module pcanon_front import pcanon_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [2:0] operation,
	input  logic [7:0] char_value,
	input  logic [7:0] read_index,
	input  logic       pop,
	output logic       head_valid,
	output cmd_t       head
);

	cmd_t            queue_q [QUEUE_DEPTH];
	logic [QP_W-1:0] wr_q;
	logic [QP_W-1:0] rd_q;
	logic [QP_W:0]   cnt_q;
	cmd_t            cmd;
	logic            push;
	logic            keep;
	logic            take;

	always_comb begin
		cmd.is_start  = (operation == OP_START);
		cmd.is_base   = (operation == OP_BASE);
		cmd.is_input  = (operation == OP_INPUT);
		cmd.is_finish = (operation == OP_FINISH);
		cmd.is_read   = (operation == OP_READ);
		cmd.ch        = char_value;
		cmd.idx       = read_index;
	end

	// Operation codes that mean nothing are dropped here.
	assign in_stall   = (cnt_q == (QP_W+1)'(QUEUE_DEPTH));
	assign push       = in_valid && !in_stall;
	assign keep       = push && (cmd.is_start || cmd.is_base || cmd.is_input ||
		cmd.is_finish || cmd.is_read);
	assign head_valid = (cnt_q != '0);
	assign head       = queue_q[rd_q];
	assign take       = pop && head_valid;

	always_ff @(posedge clk) begin
		if (keep) begin
			queue_q[wr_q] <= cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (keep) begin
				wr_q <= wr_q + QP_W'(1);
			end
			if (take) begin
				rd_q <= rd_q + QP_W'(1);
			end
			if (keep && !take) begin
				cnt_q <= cnt_q + (QP_W+1)'(1);
			end else if (take && !keep) begin
				cnt_q <= cnt_q - (QP_W+1)'(1);
			end
		end
	end

endmodule

### design/pcanon_back.sv
// Back end: sequencer that resolves path streams into the path store.
// Depends on pcanon_pkg; holds the path store and the length stack.
module pcanon_back import pcanon_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  cfg_t             cfg,
	input  logic             head_valid,
	input  cmd_t             head,
	output logic             pop,
	output logic             out_valid,
	input  logic             out_stall,
	output logic             result_kind,
	output logic             failed,
	output logic [LEN_W-1:0] result_length,
	output logic [7:0]       out_char
);

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_NEXT   = 4'd1;
	localparam logic [3:0] ST_FIN    = 4'd2;
	localparam logic [3:0] ST_DEC    = 4'd3;
	localparam logic [3:0] ST_FEED0  = 4'd4;
	localparam logic [3:0] ST_FEED1  = 4'd5;
	localparam logic [3:0] ST_COMMIT = 4'd6;
	localparam logic [3:0] ST_CHAR   = 4'd7;
	localparam logic [3:0] ST_RESULT = 4'd8;
	localparam logic [3:0] ST_READ   = 4'd9;

	logic [7:0]       mem [PATH_CAP];
	logic [LEN_W-1:0] stk [STACK_DEPTH];
	logic [7:0]       rd_data_q;

	logic [3:0]       state_q, state_d;
	logic [LEN_W-1:0] pl_q, pl_d;
	logic [SD_W-1:0]  sd_q, sd_d;
	logic [CC_W-1:0]  cc_q, cc_d;
	logic             dota_q, dota_d, dotb_q, dotb_d;
	logic             bf_q, bf_d, if_q, if_d, slash_q, slash_d;
	logic             ended_q, ended_d, babs_q, babs_d;
	logic [1:0]       sp_q, sp_d;
	logic [7:0]       fc0_q, fc0_d, fc1_q, fc1_d;
	logic [7:0]       drive_q, drive_d, sep2_q, sep2_d;
	logic [1:0]       phase_q, phase_d;
	logic             tfb_q, tfb_d, tfi_q, tfi_d, tch_q, tch_d, tres_q, tres_d;
	logic             chin_q, chin_d, cur_in_q, cur_in_d, ret_fin_q, ret_fin_d;
	logic [1:0]       feed_n_q, feed_n_d;
	logic [7:0]       ch_q, ch_d, idx_q, idx_d;
	logic             ov_q, ov_d, kind_q, kind_d, fail_q, fail_d;
	logic [LEN_W-1:0] len_q, len_d;
	logic [7:0]       char_q, char_d;

	logic             u_feed, u_commit, u_fail, fcur, cgo;
	logic [7:0]       u_c;
	logic [LEN_W-1:0] u_pl;
	logic [SD_W-1:0]  u_sd, top_v;
	logic [CC_W-1:0]  u_cc;
	logic             u_da, u_db;
	logic [POS_W-1:0] pos_v, n_v, lim10;
	logic [LEN_W-1:0] lim;
	logic             mem_we, stk_we, rd_en;
	logic [ADDR_W-1:0] mem_wa;
	logic [7:0]       mem_wd;
	logic [SP_W-1:0]  stk_wa;

	logic [7:0]       up;
	logic             prefix, absolute, feeding, out_free, finish_fail;

	assign lim   = (cfg.buf_size < LEN_W'(PATH_CAP)) ? cfg.buf_size : LEN_W'(PATH_CAP);
	assign lim10 = POS_W'(lim);
	assign fcur  = cur_in_q ? if_q : bf_q;

	always_comb begin
		u_feed   = 1'b0;
		u_commit = 1'b0;
		u_c      = ch_q;
		case (state_q)
			ST_FEED0: begin
				u_c    = fc0_q;
				u_feed = (feed_n_q != 2'd0);
			end
			ST_FEED1: begin
				u_c    = fc1_q;
				u_feed = (feed_n_q == 2'd2);
			end
			ST_CHAR: begin
				u_feed = !ended_q && (ch_q != 8'd0) && (sp_q == 2'd3) && (cur_in_q || babs_q);
			end
			ST_COMMIT: begin
				u_commit = cur_in_q || babs_q;
			end
			default: begin
				u_feed = 1'b0;
			end
		endcase
	end

	always_comb begin
		u_pl   = pl_q;
		u_sd   = sd_q;
		u_cc   = cc_q;
		u_da   = dota_q;
		u_db   = dotb_q;
		u_fail = 1'b0;
		mem_we = 1'b0;
		mem_wa = '0;
		mem_wd = u_c;
		stk_we = 1'b0;
		stk_wa = sd_q[SP_W-1:0];
		top_v  = sd_q - SD_W'(1);
		n_v    = POS_W'(pl_q);
		pos_v  = POS_W'(pl_q) + POS_W'(pl_q > ROOT_LEN) + POS_W'(cc_q);
		cgo    = 1'b0;
		if (!fcur) begin
			if (u_commit) begin
				cgo = 1'b1;
			end else if (u_feed) begin
				if (u_c == cfg.sep) begin
					cgo = 1'b1;
				end else if (POS_W'(cc_q) + POS_W'(1) >= POS_W'(NAME_LIMIT)) begin
					u_fail = 1'b1;
				end else begin
					if (pos_v < POS_W'(PATH_CAP)) begin
						mem_we = 1'b1;
						mem_wa = pos_v[ADDR_W-1:0];
					end
					if (cc_q == '0) begin
						u_da = (u_c == CH_DOT);
					end else if (cc_q == CC_W'(1)) begin
						u_db = (u_c == CH_DOT);
					end
					u_cc = cc_q + CC_W'(1);
				end
			end
		end
		if (cgo) begin
			u_cc = '0;
			if (cc_q == '0) begin
				u_cc = '0;
			end else if (cc_q == CC_W'(1) && dota_q) begin
				u_cc = '0;
			end else if (cc_q == CC_W'(2) && dota_q && dotb_q) begin
				if (sd_q != '0) begin
					u_sd = top_v;
					u_pl = stk[top_v[SP_W-1:0]];
				end
			end else if (sd_q >= SD_W'(STACK_DEPTH)) begin
				u_fail = 1'b1;
			end else begin
				if (pl_q > ROOT_LEN) begin
					if (n_v + POS_W'(1) >= lim10) begin
						u_fail = 1'b1;
					end else begin
						mem_we = 1'b1;
						mem_wa = n_v[ADDR_W-1:0];
						mem_wd = cfg.sep;
						n_v    = n_v + POS_W'(1);
					end
				end
				if (!u_fail) begin
					if (n_v + POS_W'(cc_q) >= lim10) begin
						u_fail = 1'b1;
					end else begin
						stk_we = 1'b1;
						u_sd   = sd_q + SD_W'(1);
						u_pl   = LEN_W'(n_v + POS_W'(cc_q));
					end
				end
			end
		end
	end

	always_comb begin
		up       = ((fc0_q >= CH_LA) && (fc0_q <= CH_LZ)) ? (fc0_q - CASE_GAP) : fc0_q;
		prefix   = (sp_q == 2'd2) && (fc1_q == CH_COLON) && (up >= CH_UA) && (up <= CH_UZ);
		absolute = prefix || ((sp_q != 2'd0) && (fc0_q == cfg.sep));
		feeding  = cur_in_q || absolute;
	end

	assign out_free    = !ov_q || !out_stall;
	assign finish_fail = slash_q || bf_q || if_q || (cfg.buf_size < MIN_SIZE);

	always_comb begin
		state_d   = state_q;
		pl_d      = u_pl;
		sd_d      = u_sd;
		cc_d      = u_cc;
		dota_d    = u_da;
		dotb_d    = u_db;
		bf_d      = bf_q || (u_fail && !cur_in_q);
		if_d      = if_q || (u_fail && cur_in_q);
		slash_d   = slash_q;
		ended_d   = ended_q;
		babs_d    = babs_q;
		sp_d      = sp_q;
		fc0_d     = fc0_q;
		fc1_d     = fc1_q;
		drive_d   = drive_q;
		sep2_d    = sep2_q;
		phase_d   = phase_q;
		tfb_d     = tfb_q;
		tfi_d     = tfi_q;
		tch_d     = tch_q;
		tres_d    = tres_q;
		chin_d    = chin_q;
		cur_in_d  = cur_in_q;
		ret_fin_d = ret_fin_q;
		feed_n_d  = feed_n_q;
		ch_d      = ch_q;
		idx_d     = idx_q;
		ov_d      = ov_q && out_stall;
		kind_d    = kind_q;
		fail_d    = fail_q;
		len_d     = len_q;
		char_d    = char_q;
		pop       = 1'b0;
		rd_en     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (head_valid) begin
					pop  = 1'b1;
					ch_d = head.ch;
					if (head.is_start) begin
						pl_d    = ROOT_LEN;
						sd_d    = '0;
						cc_d    = '0;
						fc0_d   = '0;
						fc1_d   = '0;
						sp_d    = '0;
						drive_d = CH_DRIVE;
						sep2_d  = cfg.sep;
						ended_d = 1'b0;
						babs_d  = 1'b0;
						bf_d    = 1'b0;
						if_d    = 1'b0;
						slash_d = 1'b0;
						dota_d  = 1'b0;
						dotb_d  = 1'b0;
						phase_d = 2'd1;
					end else if (head.is_base) begin
						tch_d   = (phase_q == 2'd1);
						chin_d  = 1'b0;
						state_d = ST_NEXT;
					end else if (head.is_input) begin
						tfb_d   = (phase_q == 2'd1);
						tch_d   = (phase_q != 2'd3);
						chin_d  = 1'b1;
						state_d = ST_NEXT;
					end else if (head.is_finish) begin
						tfb_d   = (phase_q == 2'd1);
						tfi_d   = (phase_q != 2'd3);
						tres_d  = 1'b1;
						state_d = ST_NEXT;
					end else begin
						rd_en   = 1'b1;
						idx_d   = head.idx;
						state_d = ST_READ;
					end
				end
			end
			ST_NEXT: begin
				if (tfb_q) begin
					tfb_d    = 1'b0;
					cur_in_d = 1'b0;
					state_d  = ST_FIN;
				end else if (tfi_q) begin
					tfi_d    = 1'b0;
					cur_in_d = 1'b1;
					state_d  = ST_FIN;
				end else if (tch_q) begin
					tch_d    = 1'b0;
					cur_in_d = chin_q;
					state_d  = ST_CHAR;
				end else if (tres_q) begin
					tres_d  = 1'b0;
					state_d = ST_RESULT;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_FIN: begin
				ret_fin_d = 1'b1;
				state_d   = (sp_q != 2'd3) ? ST_DEC : ST_COMMIT;
			end
			ST_DEC: begin
				sp_d     = 2'd3;
				feed_n_d = (feeding && !prefix) ? sp_q : 2'd0;
				if (cur_in_q) begin
					if (absolute) begin
						pl_d = ROOT_LEN;
						sd_d = '0;
						cc_d = '0;
						bf_d = 1'b0;
					end
				end else begin
					babs_d = absolute;
				end
				if (prefix) begin
					drive_d = up;
				end
				state_d = ST_FEED0;
			end
			ST_FEED0: begin
				state_d = ST_FEED1;
			end
			ST_FEED1: begin
				state_d = ret_fin_q ? ST_COMMIT : ST_NEXT;
			end
			ST_COMMIT: begin
				cc_d    = '0;
				sp_d    = '0;
				fc0_d   = '0;
				fc1_d   = '0;
				ended_d = 1'b0;
				phase_d = cur_in_q ? 2'd3 : 2'd2;
				state_d = ST_NEXT;
			end
			ST_CHAR: begin
				state_d = ST_NEXT;
				if (!ended_q) begin
					if (ch_q == 8'd0) begin
						ended_d = 1'b1;
					end else begin
						if (ch_q == CH_SLASH) begin
							slash_d = 1'b1;
						end
						if (sp_q == 2'd0) begin
							fc0_d = ch_q;
							sp_d  = 2'd1;
						end else if (sp_q == 2'd1) begin
							fc1_d     = ch_q;
							sp_d      = 2'd2;
							ret_fin_d = 1'b0;
							state_d   = ST_DEC;
						end
					end
				end
			end
			ST_RESULT: begin
				if (out_free) begin
					ov_d    = 1'b1;
					kind_d  = 1'b0;
					fail_d  = finish_fail;
					len_d   = finish_fail ? '0 : pl_q;
					char_d  = '0;
					state_d = ST_NEXT;
				end
			end
			ST_READ: begin
				if (out_free) begin
					ov_d   = 1'b1;
					kind_d = 1'b1;
					fail_d = 1'b0;
					len_d  = pl_q;
					if (LEN_W'(idx_q) >= pl_q) begin
						char_d = '0;
					end else if (idx_q == 8'd0) begin
						char_d = drive_q;
					end else if (idx_q == 8'd1) begin
						char_d = CH_COLON;
					end else if (idx_q == 8'd2) begin
						char_d = sep2_q;
					end else begin
						char_d = rd_data_q;
					end
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (rd_en) begin
			rd_data_q <= mem[head.idx[ADDR_W-1:0]];
		end
		if (stk_we) begin
			stk[stk_wa] <= pl_q;
		end
		ch_q   <= ch_d;
		idx_q  <= idx_d;
		kind_q <= kind_d;
		fail_q <= fail_d;
		len_q  <= len_d;
		char_q <= char_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			pl_q      <= ROOT_LEN;
			sd_q      <= '0;
			cc_q      <= '0;
			dota_q    <= 1'b0;
			dotb_q    <= 1'b0;
			bf_q      <= 1'b0;
			if_q      <= 1'b0;
			slash_q   <= 1'b0;
			ended_q   <= 1'b0;
			babs_q    <= 1'b0;
			sp_q      <= '0;
			fc0_q     <= '0;
			fc1_q     <= '0;
			drive_q   <= CH_DRIVE;
			sep2_q    <= CH_BACKSLASH;
			phase_q   <= 2'd1;
			tfb_q     <= 1'b0;
			tfi_q     <= 1'b0;
			tch_q     <= 1'b0;
			tres_q    <= 1'b0;
			chin_q    <= 1'b0;
			cur_in_q  <= 1'b0;
			ret_fin_q <= 1'b0;
			feed_n_q  <= '0;
			ov_q      <= 1'b0;
		end else begin
			state_q   <= state_d;
			pl_q      <= pl_d;
			sd_q      <= sd_d;
			cc_q      <= cc_d;
			dota_q    <= dota_d;
			dotb_q    <= dotb_d;
			bf_q      <= bf_d;
			if_q      <= if_d;
			slash_q   <= slash_d;
			ended_q   <= ended_d;
			babs_q    <= babs_d;
			sp_q      <= sp_d;
			fc0_q     <= fc0_d;
			fc1_q     <= fc1_d;
			drive_q   <= drive_d;
			sep2_q    <= sep2_d;
			phase_q   <= phase_d;
			tfb_q     <= tfb_d;
			tfi_q     <= tfi_d;
			tch_q     <= tch_d;
			tres_q    <= tres_d;
			chin_q    <= chin_d;
			cur_in_q  <= cur_in_d;
			ret_fin_q <= ret_fin_d;
			feed_n_q  <= feed_n_d;
			ov_q      <= ov_d;
		end
	end

	assign out_valid     = ov_q;
	assign result_kind   = kind_q;
	assign failed        = fail_q;
	assign result_length = len_q;
	assign out_char      = char_q;

endmodule

### design/path_canonicalizer.sv
// Top level of the path canonicalizer: configuration registers, front and back.
// Depends on pcanon_pkg, pcanon_front and pcanon_back.
//
// Items arrive on the input channel (in_valid, in_stall) with an operation,
// a character and a read index; results leave on the output channel
// (out_valid, out_stall). A transfer happens when valid is high and stall low.
// Start and character operations give no result; finish gives the status and
// length, and read gives one stored character.
// The front queues up to four items, so the sender is stalled only when the
// queue is full. The back sequencer takes one item at a time and takes no
// new item until it is through with the last; character and finish items
// pass through the per-step sequencer that feeds and commits components
// through the one write port of the path store.
// A result waits in the output register while the receiver stalls; the back
// keeps working on items that give no result meanwhile.
// Reset empties the queue and begins a fresh job with a buffer size of 256 and
// a backslash separator. The user must write configuration only while no item
// is in flight; the block itself does not enforce it.
module path_canonicalizer import pcanon_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [2:0]       operation,
	input  logic [7:0]       char_value,
	input  logic [7:0]       read_index,
	output logic             out_valid,
	input  logic             out_stall,
	output logic             result_kind,
	output logic             failed,
	output logic [LEN_W-1:0] result_length,
	output logic [7:0]       out_char,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [LEN_W-1:0] cfg_wdata
);

	cfg_t cfg_q;
	logic head_valid;
	cmd_t head;
	logic pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.buf_size <= RESET_SIZE;
			cfg_q.sep      <= CH_BACKSLASH;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_OUTPUT_SIZE: cfg_q.buf_size <= cfg_wdata;
				REG_SEPARATOR:   cfg_q.sep <= cfg_wdata[7:0];
				default:         cfg_q <= cfg_q;
			endcase
		end
	end

	pcanon_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.operation  (operation),
		.char_value (char_value),
		.read_index (read_index),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	pcanon_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.head_valid    (head_valid),
		.head          (head),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.result_kind   (result_kind),
		.failed        (failed),
		.result_length (result_length),
		.out_char      (out_char)
	);

	// A successful finish always reports at least the drive root.
	a_finish_len: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !result_kind && !failed) |-> (result_length >= ROOT_LEN))
		else $error("finish transfer with a length below the root");

	// A read transfer never reports failure.
	a_read_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && result_kind) |-> !failed)
		else $error("read transfer flagged as failed");

	// A failed finish reports zero length.
	a_fail_len: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !result_kind && failed) |-> (result_length == '0))
		else $error("failed finish transfer with nonzero length");

endmodule
